// ===== hw/rtl/dmbs_pkg.sv =====
// Shared types, codes and helpers of the density map bilinear sampler.
`default_nettype none
package dmbs_pkg;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam logic [2:0] CSR_DISK_RADIUS  = 3'd0;
   localparam logic [2:0] CSR_SUN_OFFSET_X = 3'd1;
   localparam logic [2:0] CSR_SUN_OFFSET_Y = 3'd2;
   localparam logic [2:0] CSR_MAP_WIDTH    = 3'd3;
   localparam logic [2:0] CSR_MAP_HEIGHT   = 3'd4;

   typedef struct packed {
      logic [15:0]        disk_radius;
      logic signed [16:0] sun_offset_x;
      logic signed [16:0] sun_offset_y;
      logic [9:0]         map_width;
      logic [9:0]         map_height;
   } cfg_type;

   // Classified item handed from the front end to the back end.
   typedef struct packed {
      logic        opcode;
      logic [8:0]  pixel_col;
      logic [8:0]  pixel_row;
      logic [7:0]  pixel_value;
      logic [16:0] ax;
      logic [16:0] ay;
      logic        lo_x;
      logic        hi_x;
      logic        lo_y;
      logic        hi_y;
      logic [8:0]  az;
   } item_type;

   // Twice the disk radius, with a zero radius taken as one.
   function automatic logic [16:0] two_radius(input logic [15:0] radius);
      logic [16:0] result;
      result = (radius == 16'd0) ? 17'd2 : {radius, 1'b0};
      return result;
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/dmbs_front.sv =====
// Front end: accepts items, maps sector coordinates into map space and classifies them.
`default_nettype none
module dmbs_front #(
   parameter int SECTOR_SIZE = 8
) (
   input  wire                    clock,
   input  wire                    reset,
   input  dmbs_pkg::cfg_type      cfg,
   input  wire                    req_push,
   output logic                   req_full,
   input  wire                    req_opcode,
   input  wire [8:0]              req_pixel_col,
   input  wire [8:0]              req_pixel_row,
   input  wire [7:0]              req_pixel_value,
   input  wire signed [15:0]      req_sector_x,
   input  wire signed [15:0]      req_sector_y,
   input  wire signed [15:0]      req_sector_z,
   input  wire                    fifo_full,
   output logic                   fifo_push,
   output dmbs_pkg::item_type     fifo_item
);

   localparam int PW = 18 + $clog2(SECTOR_SIZE + 1);
   localparam logic signed [PW-1:0] SS_S = PW'(SECTOR_SIZE);

   logic [16:0]          two_r;
   logic signed [PW-1:0] two_r_s;
   logic signed [PW-1:0] rad_s;
   logic signed [PW-1:0] px;
   logic signed [PW-1:0] py;
   logic signed [PW-1:0] ax_s;
   logic signed [PW-1:0] ay_s;
   logic signed [16:0]   z_ext;
   logic [16:0]          z_mag;
   logic                 take;
   logic                 vld_ff;
   logic                 vld_in;
   dmbs_pkg::item_type   item_in;
   dmbs_pkg::item_type   item_ff;

   always_comb begin
      two_r   = dmbs_pkg::two_radius(cfg.disk_radius);
      two_r_s = $signed(PW'(two_r));
      rad_s   = $signed(PW'(two_r >> 1));
      px      = PW'(req_sector_x) * SS_S + PW'(cfg.sun_offset_x);
      py      = -(PW'(req_sector_y)) * SS_S + PW'(cfg.sun_offset_y);
      ax_s    = px + rad_s;
      ay_s    = py + rad_s;
      z_ext   = 17'(req_sector_z);
      z_mag   = (z_ext < 0) ? 17'(-z_ext) : 17'(z_ext);

      item_in.opcode      = req_opcode;
      item_in.pixel_col   = req_pixel_col;
      item_in.pixel_row   = req_pixel_row;
      item_in.pixel_value = req_pixel_value;
      item_in.ax          = ax_s[16:0];
      item_in.ay          = ay_s[16:0];
      item_in.lo_x        = ax_s < 0;
      item_in.hi_x        = ax_s >= two_r_s;
      item_in.lo_y        = ay_s < 0;
      item_in.hi_y        = ay_s >= two_r_s;
      item_in.az          = (z_mag > 17'd256) ? 9'd256 : z_mag[8:0];
   end

   assign req_full  = vld_ff && fifo_full;
   assign take      = req_push && !req_full;
   assign fifo_push = vld_ff && !fifo_full;
   assign fifo_item = item_ff;

   always_comb begin
      if (take) begin
         vld_in = 1'b1;
      end else if (fifo_push) begin
         vld_in = 1'b0;
      end else begin
         vld_in = vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= item_in;
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/dmbs_fifo.sv =====
// Short queue of classified items between the front end and the back end.
`default_nettype none
module dmbs_fifo (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    push,
   input  dmbs_pkg::item_type     item_in,
   input  wire                    pop,
   output dmbs_pkg::item_type     item_out,
   output logic                   full,
   output logic                   empty
);

   localparam int DEPTH = 4;
   localparam int PTRW  = $clog2(DEPTH);

   dmbs_pkg::item_type  entry_ff [DEPTH];
   logic [PTRW-1:0]     wr_ptr_ff;
   logic [PTRW-1:0]     rd_ptr_ff;
   logic [PTRW:0]       count_ff;
   logic [PTRW:0]       count_in;

   assign full     = count_ff == (PTRW+1)'(DEPTH);
   assign empty    = count_ff == '0;
   assign item_out = entry_ff[rd_ptr_ff];

   always_comb begin
      unique case ({push, pop})
         2'b10:   count_in = count_ff + (PTRW+1)'(1);
         2'b01:   count_in = count_ff - (PTRW+1)'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + PTRW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PTRW'(1);
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= item_in;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (PTRW+1)'(DEPTH))
      else $error("queue count beyond depth");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      !(pop && empty))
      else $error("transfer out of an empty queue");
   a_push_count: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + (PTRW+1)'(1)))
      else $error("queue count missed a transfer in");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/dmbs_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, for the map-space transform.
`default_nettype none
module dmbs_div #(
   parameter int LW = 9
) (
   input  wire                 clock,
   input  wire                 enable,
   input  wire [16+LW:0]       dividend,
   input  wire [16:0]          divisor,
   output logic [LW+15:0]      quotient
);

   localparam int QW = LW + 16;

   logic [16:0]   rem_src [QW];
   logic [QW-1:0] bit_src [QW];
   logic [QW-1:0] quo_src [QW];
   logic [16:0]   rem_ff  [QW];
   logic [QW-1:0] bit_ff  [QW];
   logic [QW-1:0] quo_ff  [QW];

   // The dividend is known to give a quotient below 2^QW, so the leading
   // part already lies below the divisor.
   assign rem_src[0] = dividend[16+LW:LW];
   assign bit_src[0] = {dividend[LW-1:0], 16'd0};
   assign quo_src[0] = '0;

   for (genvar s = 1; s < QW; s++) begin : g_link
      assign rem_src[s] = rem_ff[s-1];
      assign bit_src[s] = bit_ff[s-1];
      assign quo_src[s] = quo_ff[s-1];
   end

   for (genvar s = 0; s < QW; s++) begin : g_stage
      logic [17:0] trial;
      logic        ge;
      assign trial = {rem_src[s], bit_src[s][QW-1]};
      assign ge    = trial >= {1'b0, divisor};

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[s] <= ge ? 17'(trial - {1'b0, divisor}) : trial[16:0];
            bit_ff[s] <= bit_src[s] << 1;
            quo_ff[s] <= {quo_src[s][QW-2:0], ge};
         end
      end
   end

   assign quotient = quo_ff[QW-1];

endmodule
`default_nettype wire

// ===== hw/rtl/dmbs_back.sv =====
// Back end: transform division, banked texel map, bilinear blend, dropoff and result register.
`default_nettype none
module dmbs_back #(
   parameter int MAX_MAP_WIDTH  = 512,
   parameter int MAX_MAP_HEIGHT = 512
) (
   input  wire                    clock,
   input  wire                    reset,
   input  dmbs_pkg::cfg_type      cfg,
   input  wire                    fifo_empty,
   input  dmbs_pkg::item_type     fifo_item,
   output logic                   fifo_pop,
   output logic                   rsp_empty,
   input  wire                    rsp_pop,
   output logic [7:0]             rsp_density
);

   localparam int LWX = $clog2(MAX_MAP_WIDTH);
   localparam int LWY = $clog2(MAX_MAP_HEIGHT);
   localparam int LWD = (LWX > LWY) ? LWX : LWY;
   localparam int QW  = LWD + 16;
   localparam int AW  = 17 + LWD;
   localparam int HW  = (MAX_MAP_WIDTH + 1) / 2;
   localparam int HH  = (MAX_MAP_HEIGHT + 1) / 2;
   localparam int BD  = HW * HH;
   localparam int BAW = (BD > 1) ? $clog2(BD) : 1;

   typedef struct packed {
      logic       opcode;
      logic [8:0] pixel_col;
      logic [8:0] pixel_row;
      logic [7:0] pixel_value;
      logic       lo_x;
      logic       hi_x;
      logic       lo_y;
      logic       hi_y;
      logic [8:0] az;
   } meta_type;

   logic rsp_empty_int;

   // The whole back end moves together; it holds only while a result waits.
   logic adv;
   assign adv      = rsp_empty_int || rsp_pop;
   assign fifo_pop = adv && !fifo_empty;

   logic [16:0]    two_r;
   logic [LWD-1:0] wm1_x;
   logic [LWD-1:0] wm1_y;

   always_comb begin
      two_r = dmbs_pkg::two_radius(cfg.disk_radius);
      if (cfg.map_width == 10'd0) begin
         wm1_x = '0;
      end else if (32'(cfg.map_width) > MAX_MAP_WIDTH) begin
         wm1_x = LWD'(MAX_MAP_WIDTH - 1);
      end else begin
         wm1_x = LWD'(cfg.map_width - 10'd1);
      end
      if (cfg.map_height == 10'd0) begin
         wm1_y = '0;
      end else if (32'(cfg.map_height) > MAX_MAP_HEIGHT) begin
         wm1_y = LWD'(MAX_MAP_HEIGHT - 1);
      end else begin
         wm1_y = LWD'(cfg.map_height - 10'd1);
      end
   end

   // Scale stage: numerator of the transform.
   logic          m_vld_ff;
   meta_type      m_meta_ff;
   logic [AW-1:0] m_ax_ff;
   logic [AW-1:0] m_ay_ff;
   meta_type      m_meta_in;

   always_comb begin
      m_meta_in.opcode      = fifo_item.opcode;
      m_meta_in.pixel_col   = fifo_item.pixel_col;
      m_meta_in.pixel_row   = fifo_item.pixel_row;
      m_meta_in.pixel_value = fifo_item.pixel_value;
      m_meta_in.lo_x        = fifo_item.lo_x;
      m_meta_in.hi_x        = fifo_item.hi_x;
      m_meta_in.lo_y        = fifo_item.lo_y;
      m_meta_in.hi_y        = fifo_item.hi_y;
      m_meta_in.az          = fifo_item.az;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_vld_ff <= 1'b0;
      end else if (adv) begin
         m_vld_ff <= !fifo_empty;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m_meta_ff <= m_meta_in;
         m_ax_ff   <= AW'(fifo_item.ax) * AW'(wm1_x);
         m_ay_ff   <= AW'(fifo_item.ay) * AW'(wm1_y);
      end
   end

   // Division stages with the item's other fields carried alongside.
   logic [QW-1:0] qx;
   logic [QW-1:0] qy;
   logic          d_vld_ff  [QW];
   meta_type      d_meta_ff [QW];

   dmbs_div #(.LW(LWD)) u_div_x (
      .clock    (clock),
      .enable   (adv),
      .dividend (m_ax_ff),
      .divisor  (two_r),
      .quotient (qx)
   );

   dmbs_div #(.LW(LWD)) u_div_y (
      .clock    (clock),
      .enable   (adv),
      .dividend (m_ay_ff),
      .divisor  (two_r),
      .quotient (qy)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < QW; s++) begin
            d_vld_ff[s] <= 1'b0;
         end
      end else if (adv) begin
         d_vld_ff[0] <= m_vld_ff;
         for (int s = 1; s < QW; s++) begin
            d_vld_ff[s] <= d_vld_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         d_meta_ff[0] <= m_meta_ff;
         for (int s = 1; s < QW; s++) begin
            d_meta_ff[s] <= d_meta_ff[s-1];
         end
      end
   end

   // Address stage: clamped texel indices and bank addresses.
   meta_type       dm;
   logic [LWD-1:0] ix;
   logic [LWD-1:0] iy;
   logic [LWD-1:0] x0;
   logic [LWD-1:0] x1;
   logic [LWD-1:0] y0;
   logic [LWD-1:0] y1;
   logic [15:0]    mx;
   logic [15:0]    my;
   logic [LWX-1:0] x0n;
   logic [LWX-1:0] x1n;
   logic [LWY-1:0] y0n;
   logic [LWY-1:0] y1n;
   logic [LWX-1:0] ch [2];
   logic [LWY-1:0] rh [2];
   logic [BAW-1:0] ra [4];
   logic           we;
   logic [BAW-1:0] wa;

   always_comb begin
      dm = d_meta_ff[QW-1];
      ix = qx[QW-1:16];
      iy = qy[QW-1:16];
      priority if (dm.lo_x) begin
         x0 = '0;
         x1 = '0;
         mx = '0;
      end else if (dm.hi_x) begin
         x0 = wm1_x;
         x1 = wm1_x;
         mx = '0;
      end else begin
         x0 = ix;
         x1 = (ix == wm1_x) ? ix : ix + LWD'(1);
         mx = qx[15:0];
      end
      priority if (dm.lo_y) begin
         y0 = '0;
         y1 = '0;
         my = '0;
      end else if (dm.hi_y) begin
         y0 = wm1_y;
         y1 = wm1_y;
         my = '0;
      end else begin
         y0 = iy;
         y1 = (iy == wm1_y) ? iy : iy + LWD'(1);
         my = qy[15:0];
      end
      x0n = x0[LWX-1:0];
      x1n = x1[LWX-1:0];
      y0n = y0[LWY-1:0];
      y1n = y1[LWY-1:0];
      // Neighboring columns fall in opposite banks; equal ones share a read.
      ch[0] = x0n[0] ? (x1n >> 1) : (x0n >> 1);
      ch[1] = x0n[0] ? (x0n >> 1) : (x1n >> 1);
      rh[0] = y0n[0] ? (y1n >> 1) : (y0n >> 1);
      rh[1] = y0n[0] ? (y0n >> 1) : (y1n >> 1);
      for (int b = 0; b < 4; b++) begin
         ra[b] = BAW'(32'(rh[b / 2]) * HW + 32'(ch[b % 2]));
      end
      we = (dm.opcode == dmbs_pkg::OP_LOAD)
           && (32'(dm.pixel_col) < MAX_MAP_WIDTH)
           && (32'(dm.pixel_row) < MAX_MAP_HEIGHT);
      wa = BAW'(32'(dm.pixel_row[8:1]) * HW + 32'(dm.pixel_col[8:1]));
   end

   logic           a_vld_ff;
   logic           a_query_ff;
   logic           a_we_ff;
   logic [1:0]     a_wbank_ff;
   logic [BAW-1:0] a_wa_ff;
   logic [7:0]     a_wval_ff;
   logic [BAW-1:0] a_ra_ff [4];
   logic [3:0]     a_sel_ff;
   logic [15:0]    a_mx_ff;
   logic [15:0]    a_my_ff;
   logic [8:0]     a_az_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else if (adv) begin
         a_vld_ff <= d_vld_ff[QW-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_query_ff <= dm.opcode == dmbs_pkg::OP_QUERY;
         a_we_ff    <= we;
         a_wbank_ff <= {dm.pixel_row[0], dm.pixel_col[0]};
         a_wa_ff    <= wa;
         a_wval_ff  <= dm.pixel_value;
         for (int b = 0; b < 4; b++) begin
            a_ra_ff[b] <= ra[b];
         end
         a_sel_ff   <= {y1n[0], y0n[0], x1n[0], x0n[0]};
         a_mx_ff    <= mx;
         a_my_ff    <= my;
         a_az_ff    <= dm.az;
      end
   end

   // Memory stage: four banks by row and column parity.
   logic        r_vld_ff;
   logic [7:0]  rd_ff [4];
   logic [3:0]  r_sel_ff;
   logic [15:0] r_mx_ff;
   logic [15:0] r_my_ff;
   logic [8:0]  r_az_ff;

   for (genvar b = 0; b < 4; b++) begin : g_bank
      logic [7:0] bank_mem [BD];

      always_ff @(posedge clock) begin
         if (adv) begin
            if (a_vld_ff && a_we_ff && (a_wbank_ff == 2'(b))) begin
               bank_mem[a_wa_ff] <= a_wval_ff;
            end
            rd_ff[b] <= bank_mem[a_ra_ff[b]];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r_vld_ff <= 1'b0;
      end else if (adv) begin
         r_vld_ff <= a_vld_ff && a_query_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         r_sel_ff <= a_sel_ff;
         r_mx_ff  <= a_mx_ff;
         r_my_ff  <= a_my_ff;
         r_az_ff  <= a_az_ff;
      end
   end

   // Horizontal blend.
   logic [7:0]  v1;
   logic [7:0]  v2;
   logic [7:0]  v3;
   logic [7:0]  v4;
   logic [16:0] wx0;
   logic [24:0] top_c;
   logic [24:0] bot_c;

   always_comb begin
      v1    = rd_ff[{r_sel_ff[2], r_sel_ff[0]}];
      v2    = rd_ff[{r_sel_ff[2], r_sel_ff[1]}];
      v3    = rd_ff[{r_sel_ff[3], r_sel_ff[0]}];
      v4    = rd_ff[{r_sel_ff[3], r_sel_ff[1]}];
      wx0   = 17'd65536 - 17'(r_mx_ff);
      top_c = 25'(v1) * 25'(wx0) + 25'(v2) * 25'(r_mx_ff);
      bot_c = 25'(v3) * 25'(wx0) + 25'(v4) * 25'(r_mx_ff);
   end

   logic        h_vld_ff;
   logic [23:0] h_top_ff;
   logic [23:0] h_bot_ff;
   logic [15:0] h_my_ff;
   logic [8:0]  h_az_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         h_vld_ff <= 1'b0;
      end else if (adv) begin
         h_vld_ff <= r_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         h_top_ff <= top_c[23:0];
         h_bot_ff <= bot_c[23:0];
         h_my_ff  <= r_my_ff;
         h_az_ff  <= r_az_ff;
      end
   end

   // Vertical blend: texel units times 2^32.
   logic [40:0] v_c;
   assign v_c = 41'(h_top_ff) * 41'(17'd65536 - 17'(h_my_ff))
              + 41'(h_bot_ff) * 41'(h_my_ff);

   logic        v_vld_ff;
   logic [39:0] v_val_ff;
   logic [8:0]  v_az_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_vld_ff <= 1'b0;
      end else if (adv) begin
         v_vld_ff <= h_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         v_val_ff <= v_c[39:0];
         v_az_ff  <= h_az_ff;
      end
   end

   // Dropoff scale: max(1, 3.5 - 2.5 * value) in Q16.
   logic [18:0] half5;
   logic [17:0] scale_raw;
   logic [17:0] scale;

   always_comb begin
      half5     = (19'(v_val_ff[39:24]) * 19'd5) >> 1;
      scale_raw = 18'd229376 - half5[17:0];
      scale     = (scale_raw < 18'd65536) ? 18'd65536 : scale_raw;
   end

   logic        s_vld_ff;
   logic [39:0] s_val_ff;
   logic [8:0]  s_az_ff;
   logic [17:0] s_scale_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s_vld_ff <= 1'b0;
      end else if (adv) begin
         s_vld_ff <= v_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s_val_ff   <= v_val_ff;
         s_az_ff    <= v_az_ff;
         s_scale_ff <= scale;
      end
   end

   logic [26:0] t_prod;
   logic [16:0] t_val;
   always_comb begin
      t_prod = 27'(s_az_ff) * 27'(s_scale_ff);
      t_val  = (t_prod[26:8] > 19'd65536) ? 17'd65536 : t_prod[24:8];
   end

   logic        t_vld_ff;
   logic [39:0] t_val_ff;
   logic [16:0] t_drop_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         t_vld_ff <= 1'b0;
      end else if (adv) begin
         t_vld_ff <= s_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         t_val_ff  <= s_val_ff;
         t_drop_ff <= 17'd65536 - t_val;
      end
   end

   // Final scaling and saturation into the result register.
   logic [56:0] d_prod;
   logic [7:0]  density_c;
   always_comb begin
      d_prod    = 57'(t_val_ff) * 57'(t_drop_ff);
      density_c = (d_prod[56:48] > 9'd255) ? 8'd255 : d_prod[55:48];
   end

   logic       out_vld_ff;
   logic [7:0] out_density_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         out_vld_ff <= t_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_density_ff <= density_c;
      end
   end

   assign rsp_empty_int = !out_vld_ff;
   assign rsp_empty     = rsp_empty_int;
   assign rsp_density   = out_density_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/density_map_bilinear_sampler_unit.sv =====
// Throughput: one item per cycle; the back end holds only while a result waits unread.
// Loads give no result; they write the banked map in order with the queries around them.
// Synchronous reset clears all valid state and loads the register defaults; map contents
// are undefined until written.
`default_nettype none
module density_map_bilinear_sampler_unit #(
   parameter int MAX_MAP_WIDTH  = 512,
   parameter int MAX_MAP_HEIGHT = 512,
   parameter int SECTOR_SIZE    = 8
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               csr_we,
   input  wire [2:0]         csr_index,
   input  wire [16:0]        csr_wdata,
   input  wire               req_push,
   output logic              req_full,
   input  wire               req_opcode,
   input  wire [8:0]         req_pixel_col,
   input  wire [8:0]         req_pixel_row,
   input  wire [7:0]         req_pixel_value,
   input  wire signed [15:0] req_sector_x,
   input  wire signed [15:0] req_sector_y,
   input  wire signed [15:0] req_sector_z,
   output logic              rsp_empty,
   input  wire               rsp_pop,
   output logic [7:0]        rsp_density
);

   dmbs_pkg::cfg_type  cfg_ff;
   dmbs_pkg::item_type front_item;
   dmbs_pkg::item_type fifo_item;
   logic               fifo_push;
   logic               fifo_pop;
   logic               fifo_full;
   logic               fifo_empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.disk_radius  <= 16'd50000;
         cfg_ff.sun_offset_x <= 17'sd25000;
         cfg_ff.sun_offset_y <= 17'sd0;
         cfg_ff.map_width    <= 10'd512;
         cfg_ff.map_height   <= 10'd512;
      end else if (csr_we) begin
         unique case (csr_index)
            dmbs_pkg::CSR_DISK_RADIUS:  cfg_ff.disk_radius  <= csr_wdata[15:0];
            dmbs_pkg::CSR_SUN_OFFSET_X: cfg_ff.sun_offset_x <= csr_wdata;
            dmbs_pkg::CSR_SUN_OFFSET_Y: cfg_ff.sun_offset_y <= csr_wdata;
            dmbs_pkg::CSR_MAP_WIDTH:    cfg_ff.map_width    <= csr_wdata[9:0];
            dmbs_pkg::CSR_MAP_HEIGHT:   cfg_ff.map_height   <= csr_wdata[9:0];
            default: ;
         endcase
      end
   end

   dmbs_front #(.SECTOR_SIZE(SECTOR_SIZE)) u_front (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_opcode      (req_opcode),
      .req_pixel_col   (req_pixel_col),
      .req_pixel_row   (req_pixel_row),
      .req_pixel_value (req_pixel_value),
      .req_sector_x    (req_sector_x),
      .req_sector_y    (req_sector_y),
      .req_sector_z    (req_sector_z),
      .fifo_full       (fifo_full),
      .fifo_push       (fifo_push),
      .fifo_item       (front_item)
   );

   dmbs_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (fifo_push),
      .item_in  (front_item),
      .pop      (fifo_pop),
      .item_out (fifo_item),
      .full     (fifo_full),
      .empty    (fifo_empty)
   );

   dmbs_back #(
      .MAX_MAP_WIDTH  (MAX_MAP_WIDTH),
      .MAX_MAP_HEIGHT (MAX_MAP_HEIGHT)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .fifo_empty  (fifo_empty),
      .fifo_item   (fifo_item),
      .fifo_pop    (fifo_pop),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_density (rsp_density)
   );

endmodule
`default_nettype wire

// ===== bench/density_checker.sv =====
// Checker for the density map sampler: predicts each query result and compares it.
`timescale 1ns / 100ps
module density_checker #(
   parameter int MAP_W  = 512,
   parameter int MAP_H  = 512,
   parameter int SECTOR = 8
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               csr_we,
   input  wire [2:0]         csr_index,
   input  wire [16:0]        csr_wdata,
   input  wire               req_push,
   input  wire               req_full,
   input  wire               req_opcode,
   input  wire [8:0]         req_pixel_col,
   input  wire [8:0]         req_pixel_row,
   input  wire [7:0]         req_pixel_value,
   input  wire signed [15:0] req_sector_x,
   input  wire signed [15:0] req_sector_y,
   input  wire signed [15:0] req_sector_z,
   input  wire               rsp_empty,
   input  wire               rsp_pop,
   input  wire [7:0]         rsp_density,
   output int                errors,
   output int                pending,
   output int                queries_seen,
   output int                loads_seen
);

   dmbs_pkg::cfg_type cfg;
   byte unsigned      texels [0:MAP_W*MAP_H-1];
   logic [7:0]        density_q [$];

   function automatic longint floor_div(longint num, longint den);
      if (num >= 0) return num / den;
      return -((-num + den - 1) / den);
   endfunction

   function automatic longint clampl(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   // Position along one axis: clamped texel pair plus Q16 weight of the upper texel.
   function automatic void place(input longint p, input longint r, input longint size,
                                 output longint i0, output longint i1,
                                 output longint frac);
      longint fq;
      fq = floor_div((p + r) * (size - 1) * 65536, 2 * r);
      frac = fq & 64'hFFFF;
      i0 = clampl(fq >>> 16, 0, size - 1);
      i1 = clampl((fq >>> 16) + 1, 0, size - 1);
   endfunction

   function automatic logic [7:0] sector_density(logic signed [15:0] sx,
                                                  logic signed [15:0] sy,
                                                  logic signed [15:0] sz);
      longint r, w, h, px, py, x0, x1, y0, y1, mx, my, az;
      longint unsigned top, bot, v, scale, t, d;
      r = (cfg.disk_radius == 0) ? 1 : longint'(cfg.disk_radius);
      w = clampl(cfg.map_width, 1, MAP_W);
      h = clampl(cfg.map_height, 1, MAP_H);
      px = longint'(sx) * SECTOR + longint'(cfg.sun_offset_x);
      py = -longint'(sy) * SECTOR + longint'(cfg.sun_offset_y);
      place(px, r, w, x0, x1, mx);
      place(py, r, h, y0, y1, my);
      top = texels[y0*MAP_W + x0] * (65536 - mx) + texels[y0*MAP_W + x1] * mx;
      bot = texels[y1*MAP_W + x0] * (65536 - mx) + texels[y1*MAP_W + x1] * mx;
      v = top * (65536 - my) + bot * my;
      scale = 229376 - ((5 * (v >> 24)) >> 1);
      if (scale < 65536) scale = 65536;
      az = (sz < 0) ? -longint'(sz) : longint'(sz);
      if (az > 256) az = 256;
      t = (az * scale) >> 8;
      if (t > 65536) t = 65536;
      d = (v * (65536 - t)) >> 48;
      if (d > 255) d = 255;
      return d[7:0];
   endfunction

   task automatic report(input string what);
      $display("%0t MISMATCH: %s", $realtime, what);
      errors++;
   endtask

   initial begin
      errors = 0;
      pending = 0;
      queries_seen = 0;
      loads_seen = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         cfg.disk_radius  <= 16'd50000;
         cfg.sun_offset_x <= 17'sd25000;
         cfg.sun_offset_y <= 17'sd0;
         cfg.map_width    <= 10'd512;
         cfg.map_height   <= 10'd512;
         density_q.delete();
      end else begin
         if (req_push && !req_full) begin
            if (req_opcode == dmbs_pkg::OP_LOAD) begin
               texels[req_pixel_row*MAP_W + req_pixel_col] = req_pixel_value;
               loads_seen++;
            end else begin
               density_q.push_back(sector_density(req_sector_x, req_sector_y,
                                                  req_sector_z));
               queries_seen++;
            end
         end
         if (rsp_pop && !rsp_empty) begin
            if (density_q.size() == 0)
               report($sformatf("density %0d with no query outstanding", rsp_density));
            else begin
               if (rsp_density !== density_q[0])
                  report($sformatf("density %0d, predicted %0d", rsp_density, density_q[0]));
               void'(density_q.pop_front());
            end
         end
         // Register writes take effect for transfers after this edge.
         if (csr_we) begin
            case (csr_index)
               dmbs_pkg::CSR_DISK_RADIUS:  cfg.disk_radius  <= csr_wdata[15:0];
               dmbs_pkg::CSR_SUN_OFFSET_X: cfg.sun_offset_x <= csr_wdata;
               dmbs_pkg::CSR_SUN_OFFSET_Y: cfg.sun_offset_y <= csr_wdata;
               dmbs_pkg::CSR_MAP_WIDTH:    cfg.map_width    <= csr_wdata[9:0];
               dmbs_pkg::CSR_MAP_HEIGHT:   cfg.map_height   <= csr_wdata[9:0];
               default: ;
            endcase
         end
      end
      pending <= density_q.size();
   end

endmodule

// ===== bench/tb_top.sv =====
// Top of the density map sampler testbench: stimulus, pressure and the verdict.
`timescale 1ns / 100ps
module tb_top;

   localparam int  MAP_W = 512;
   localparam int  MAP_H = 512;
   localparam int  LIMIT = 1_000_000;
   localparam int  SETTLE = 40;

   logic               clock;
   logic               reset;
   logic               csr_we;
   logic [2:0]         csr_index;
   logic [16:0]        csr_wdata;
   logic               req_push;
   logic               req_full;
   logic               req_opcode;
   logic [8:0]         req_pixel_col;
   logic [8:0]         req_pixel_row;
   logic [7:0]         req_pixel_value;
   logic signed [15:0] req_sector_x;
   logic signed [15:0] req_sector_y;
   logic signed [15:0] req_sector_z;
   logic               rsp_empty;
   logic               rsp_pop;
   logic [7:0]         rsp_density;
   int                 errors, pending, queries_seen, loads_seen;
   int                 cycles;
   bit                 calm;
   bit                 hold_req;
   bit                 written [0:MAP_W*MAP_H-1];
   longint             radius, off_x, off_y, width_used, height_used;

   density_map_bilinear_sampler_unit u_top (.*);

   density_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial cycles = 0;
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("TEST FAILED");
         $finish;
      end
   end

   // Result side: random stalls, plus one long hold-off on request.
   initial begin
      int n, r;
      rsp_pop = 1'b0;
      @(negedge reset);
      forever begin
         r = $urandom_range(0, 99);
         n = (r < 60) ? 0 : (r < 90) ? $urandom_range(1, 3) : $urandom_range(5, 30);
         if (hold_req) begin
            hold_req = 1'b0;
            rsp_pop <= 1'b0;
            repeat (400) @(posedge clock);
         end else if (!calm && n > 0) begin
            rsp_pop <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         @(posedge clock);
      end
   end

   function automatic longint clampl(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   // Texel index pair that a coordinate lands on, used only to keep reads on loaded texels.
   task automatic neighbors(input longint p, input longint size,
                            output longint lo, output longint hi);
      longint num, den, fq;
      num = (p + radius) * (size - 1) * 65536;
      den = 2 * radius;
      fq = (num >= 0) ? num / den : -((-num + den - 1) / den);
      lo = clampl(fq >>> 16, 0, size - 1);
      hi = clampl((fq >>> 16) + 1, 0, size - 1);
   endtask

   task automatic sender_gap();
      int r, n;
      r = $urandom_range(0, 99);
      n = (r < 75) ? 0 : (r < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
      if (!calm && n > 0) begin
         req_push <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic transfer_in();
      req_push <= 1'b1;
      do @(posedge clock); while (req_full);
   endtask

   task automatic load(input int col, input int row, input int value);
      sender_gap();
      req_opcode      <= dmbs_pkg::OP_LOAD;
      req_pixel_col   <= col[8:0];
      req_pixel_row   <= row[8:0];
      req_pixel_value <= value[7:0];
      req_sector_x    <= 16'($urandom);
      req_sector_y    <= 16'($urandom);
      req_sector_z    <= 16'($urandom);
      written[row*MAP_W + col] = 1'b1;
      transfer_in();
   endtask

   // Loads any of the four neighbor texels still unwritten, then sends the query.
   task automatic query(input logic signed [15:0] sx, input logic signed [15:0] sy,
                        input logic signed [15:0] sz);
      longint x0, x1, y0, y1;
      neighbors(longint'(sx) * 8 + off_x, width_used, x0, x1);
      neighbors(-longint'(sy) * 8 + off_y, height_used, y0, y1);
      if (!written[y0*MAP_W + x0]) load(int'(x0), int'(y0), $urandom_range(0, 255));
      if (!written[y0*MAP_W + x1]) load(int'(x1), int'(y0), $urandom_range(0, 255));
      if (!written[y1*MAP_W + x0]) load(int'(x0), int'(y1), $urandom_range(0, 255));
      if (!written[y1*MAP_W + x1]) load(int'(x1), int'(y1), $urandom_range(0, 255));
      sender_gap();
      req_opcode      <= dmbs_pkg::OP_QUERY;
      req_pixel_col   <= 9'($urandom);
      req_pixel_row   <= 9'($urandom);
      req_pixel_value <= 8'($urandom);
      req_sector_x    <= sx;
      req_sector_y    <= sy;
      req_sector_z    <= sz;
      transfer_in();
   endtask

   task automatic wait_idle();
      req_push <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic configure(input int r, input int ox, input int oy, input int w, input int h);
      int vals [5];
      vals = '{r, ox, oy, w, h};
      for (int i = 0; i < 5; i++) begin
         csr_we    <= 1'b1;
         csr_index <= 3'(i);
         csr_wdata <= 17'(vals[i]);
         @(posedge clock);
      end
      csr_we <= 1'b0;
      radius      = (r[15:0] == 0) ? 1 : longint'(r[15:0]);
      off_x       = longint'($signed(17'(ox)));
      off_y       = longint'($signed(17'(oy)));
      width_used  = clampl(w[9:0], 1, MAP_W);
      height_used = clampl(h[9:0], 1, MAP_H);
   endtask

   function automatic logic signed [15:0] aim(longint offset);
      longint s;
      if ($urandom_range(0, 9) == 0) return 16'($urandom);
      s = (longint'($urandom_range(0, 2 * radius)) - radius - offset) / 8;
      return 16'(clampl(s, -32768, 32767));
   endfunction

   function automatic logic signed [15:0] depth();
      int r;
      r = $urandom_range(0, 9);
      if (r < 4) return 16'sd0;
      if (r < 7) return 16'(($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(0, 300)));
      return 16'($urandom);
   endfunction

   task automatic random_items(input int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 3) == 0) begin
            if ($urandom_range(0, 4) == 0)
               load($urandom_range(0, MAP_W - 1), $urandom_range(0, MAP_H - 1),
                    $urandom_range(0, 255));
            else
               load($urandom_range(0, width_used - 1), $urandom_range(0, height_used - 1),
                    $urandom_range(0, 255));
         end else
            query(aim(off_x), -aim(off_y), depth());
      end
   endtask

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_push = 1'b0;
      req_opcode = dmbs_pkg::OP_LOAD;
      req_pixel_col = '0;
      req_pixel_row = '0;
      req_pixel_value = '0;
      req_sector_x = '0;
      req_sector_y = '0;
      req_sector_z = '0;
      calm = 1'b0;
      hold_req = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Small map, centered galaxy: directed edge values first.
      configure(1000, 0, 0, 8, 8);
      load(0, 0, 255);
      load(7, 7, 0);
      load(511, 511, 170);
      load(7, 0, 128);
      load(0, 7, 1);
      query(0, 0, 0);
      query(32767, -32768, 0);
      query(-32768, 32767, 256);
      query(0, 0, -32768);
      query(10, -10, 255);
      query(62, 0, 1);
      query(-125, 125, -256);
      query(125, -125, 257);
      query(-1, 1, 32767);
      wait_idle();

      // The receiver sits out while items keep coming, so the input stalls.
      hold_req = 1'b1;
      random_items(120);
      wait_idle();

      // A zero radius acts as one; out-of-range map sizes are clamped.
      configure(0, -65536, 65535, 0, 1023);
      query(0, 0, 0);
      query(-32768, 32767, 100);
      random_items(40);
      wait_idle();

      // Widest radius and full map, with no idling on either side.
      calm = 1'b1;
      configure(65535, 65535, -65536, 512, 512);
      random_items(40);
      wait_idle();
      calm = 1'b0;

      for (int k = 0; k < 3; k++) begin
         if (k == 2)
            configure($urandom_range(1, 65535), $urandom, $urandom,
                      $urandom_range(0, 1023), $urandom_range(0, 1023));
         else
            configure($urandom_range(1, 65535), $urandom, $urandom,
                      $urandom_range(1, 32), $urandom_range(1, 32));
         random_items(50);
         wait_idle();
      end

      repeat (SETTLE) @(posedge clock);
      $display("Covered %0d queries and %0d texel loads over six register settings,",
               queries_seen, loads_seen);
      $display("including zero radius, clamped map sizes and a long result back-pressure.");
      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("%0d mismatches", errors);
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/dmbs_pkg.sv
hw/rtl/dmbs_front.sv
hw/rtl/dmbs_fifo.sv
hw/rtl/dmbs_div.sv
hw/rtl/dmbs_back.sv
hw/rtl/density_map_bilinear_sampler_unit.sv
bench/density_checker.sv
bench/tb_top.sv
